[hw/rtl/mjpid_pkg.sv]
// ----------------------------------------------------------------------------
// mjpid_pkg
// Shared types and constants for the multi-joint PID torque controller.
// ----------------------------------------------------------------------------
package mjpid_pkg;

  localparam int unsigned NumJoints = 6;
  localparam int unsigned JointW    = 3;
  localparam int unsigned JIdxW     = (NumJoints > 1) ? $clog2(NumJoints) : 1;
  localparam int unsigned AngleW    = 31;
  localparam int unsigned VelW      = 28;
  localparam int unsigned TorqueW   = 25;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 60;
  localparam int unsigned GainW     = 20;
  localparam int unsigned GainRegs  = 6;

  // joint state word: position, velocity, target, integral
  localparam int unsigned StateW = 3 * AngleW + VelW;

  localparam logic signed [31:0] PiQ     = 32'sd421657428;
  localparam logic signed [31:0] TwoPiQ  = 32'sd843314857;
  localparam logic signed [31:0] HalfPiQ = 32'sd210828714;
  localparam logic [23:0]        DtQ32   = 24'd8589935;

  localparam logic [1:0] ActMeas   = 2'd0;
  localparam logic [1:0] ActTarget = 2'd1;
  localparam logic [1:0] ActTick   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegIntLim = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTqLim  = 3'd7;

  localparam logic [CfgDataW-1:0] GainsReset [GainRegs] = '{
    60'd540431976759398400, 60'd540431976759398400, 60'd540431976759398400,
    60'd202661987526688768, 60'd135107992257335296, 60'd90071994694918144
  };

  typedef struct packed {
    logic signed [AngleW-1:0] pos;
    logic signed [VelW-1:0]   vel;
    logic signed [AngleW-1:0] tgt;
    logic signed [AngleW-1:0] integ;
  } joint_state_t;

  function automatic logic signed [AngleW-1:0] home_target(input logic [JIdxW-1:0] j);
    logic signed [AngleW-1:0] r;
    case (j)
      1, 4:    r = -HalfPiQ[AngleW-1:0];
      2:       r = HalfPiQ[AngleW-1:0];
      3:       r = -PiQ[AngleW-1:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/multi_joint_pid_torque.sv]
// ----------------------------------------------------------------------------
// multi_joint_pid_torque
// Six-joint PID torque controller with clamped integrals.
// ----------------------------------------------------------------------------
// Usage: an item transfers when start is high and busy low. Action 0
// stores a joint measurement, action 1 a target, action 2 is a control tick.
// Measurement and target writes go through a RAM read, modify and write back.
// A tick, once every joint has been seen, emits one torque per joint in joint
// order, each shown for one cycle with valid_o; the sequencer takes one joint
// at a time through the steps read, wrap, scale, integrate, multiply, sum and
// saturate. Results cannot be stalled by the receiver. After reset the state
// RAM is swept once over every joint (busy high) to load zero state and the
// home pose; configuration writes are taken at any time and act at once.
// ----------------------------------------------------------------------------
module multi_joint_pid_torque (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           action_i,
  input  logic [mjpid_pkg::JointW-1:0]         joint_i,
  input  logic signed [mjpid_pkg::AngleW-1:0]  angle_i,
  input  logic signed [mjpid_pkg::VelW-1:0]    velocity_i,
  input  logic                                 velocity_valid_i,
  input  logic                                 cfg_we_i,
  input  logic [mjpid_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mjpid_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                 valid_o,
  output logic [mjpid_pkg::JointW-1:0]         joint_out_o,
  output logic signed [mjpid_pkg::TorqueW-1:0] torque_o,
  output logic                                 last_o
);

  logic [mjpid_pkg::CfgDataW-1:0] gains_q [mjpid_pkg::NumJoints];
  logic [29:0]                    int_lim_q;
  logic [23:0]                    tq_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mjpid_pkg::NumJoints; i++)
        gains_q[i] <= (i < mjpid_pkg::GainRegs) ? mjpid_pkg::GainsReset[i] : '0;
      int_lim_q <= 30'd671088640;
      tq_lim_q  <= 24'd5242880;
    end else if (cfg_we_i) begin
      for (int i = 0; i < mjpid_pkg::NumJoints; i++)
        if (i < mjpid_pkg::GainRegs && cfg_idx_i == mjpid_pkg::CfgIdxW'(i))
          gains_q[i] <= cfg_data_i;
      if (cfg_idx_i == mjpid_pkg::RegIntLim) int_lim_q <= cfg_data_i[29:0];
      if (cfg_idx_i == mjpid_pkg::RegTqLim)  tq_lim_q  <= cfg_data_i[23:0];
    end
  end

  mjpid_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy),
    .action_i, .joint_i, .angle_i, .velocity_i, .velocity_valid_i,
    .gains_i(gains_q), .int_lim_i(int_lim_q), .tq_lim_i(tq_lim_q),
    .valid_o, .joint_out_o, .torque_o, .last_o
  );

endmodule

[hw/rtl/mjpid_ram.sv]
// ----------------------------------------------------------------------------
// mjpid_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mjpid_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/mjpid_ctrl.sv]
// ----------------------------------------------------------------------------
// mjpid_ctrl
// Per-joint PID datapath and sequencer: reads joint state from the RAM,
// updates the integral and writes it back, forms the saturated torque.
// ----------------------------------------------------------------------------
module mjpid_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          action_i,
  input  logic [mjpid_pkg::JointW-1:0]        joint_i,
  input  logic signed [mjpid_pkg::AngleW-1:0] angle_i,
  input  logic signed [mjpid_pkg::VelW-1:0]   velocity_i,
  input  logic                                velocity_valid_i,
  input  logic [mjpid_pkg::CfgDataW-1:0]      gains_i [mjpid_pkg::NumJoints],
  input  logic [29:0]                         int_lim_i,
  input  logic [23:0]                         tq_lim_i,
  output logic                                valid_o,
  output logic [mjpid_pkg::JointW-1:0]        joint_out_o,
  output logic signed [mjpid_pkg::TorqueW-1:0] torque_o,
  output logic                                last_o
);

  typedef enum logic [3:0] {
    StInit, StIdle, StRead, StUpd, StErr, StDt, StInt, StMul, StSum, StOut
  } state_e;

  localparam int unsigned JIdxW = mjpid_pkg::JIdxW;
  localparam int unsigned AW    = mjpid_pkg::AngleW;

  state_e                         state_q;
  logic [JIdxW-1:0]               j_q;
  logic [mjpid_pkg::NumJoints-1:0] seen_q;
  logic [1:0]                     act_q;
  logic signed [AW-1:0]           ang_q;
  logic signed [mjpid_pkg::VelW-1:0] vel_q;
  logic                           vv_q;
  logic signed [33:0]             err_q;
  logic signed [57:0]             dt_q;
  logic signed [AW-1:0]           integ_q;
  logic signed [53:0]             p_q, i_q, d_q;
  logic signed [63:0]             acc_q;
  logic                           valid_q, last_q;
  logic [mjpid_pkg::JointW-1:0]   jout_q;
  logic signed [mjpid_pkg::TorqueW-1:0] tq_q;

  mjpid_pkg::joint_state_t rd, wd;
  logic                    we;
  logic [JIdxW-1:0]        waddr, raddr;

  mjpid_ram #(.Width(mjpid_pkg::StateW), .Depth(mjpid_pkg::NumJoints)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wd), .raddr_i(raddr), .rdata_o(rd)
  );

  logic in_range;
  assign in_range = {1'b0, joint_i} < (mjpid_pkg::JointW+1)'(mjpid_pkg::NumJoints);

  // gains of the current joint
  logic [mjpid_pkg::CfgDataW-1:0] g;
  logic signed [20:0] kp, ki, kd;
  assign g  = gains_i[j_q];
  assign kp = {1'b0, g[59:40]};
  assign ki = {1'b0, g[39:20]};
  assign kd = {1'b0, g[19:0]};

  // error wrap: the difference spans about +-5 pi, so up to three turns come off
  localparam logic signed [33:0] PiX    = 34'(mjpid_pkg::PiQ);
  localparam logic signed [33:0] TwoPiX = 34'(mjpid_pkg::TwoPiQ);

  logic signed [33:0] e0, e2;
  always_comb begin
    e0 = 34'(rd.tgt) - 34'(rd.pos);
    if (e0 > PiX + 34'sd2 * TwoPiX)       e2 = e0 - 34'sd3 * TwoPiX;
    else if (e0 > PiX + TwoPiX)           e2 = e0 - 34'sd2 * TwoPiX;
    else if (e0 > PiX)                    e2 = e0 - TwoPiX;
    else if (e0 < -PiX - 34'sd2 * TwoPiX) e2 = e0 + 34'sd3 * TwoPiX;
    else if (e0 < -PiX - TwoPiX)          e2 = e0 + 34'sd2 * TwoPiX;
    else if (e0 < -PiX)                   e2 = e0 + TwoPiX;
    else                                  e2 = e0;
  end

  logic signed [33:0] dtr, isum, ilim;
  logic signed [57:0] dtp;
  assign dtp  = dt_q + 58'sd2147483648;
  assign dtr  = 34'(dtp >>> 32);
  assign isum = 34'(rd.integ) + dtr;
  assign ilim = {4'b0, int_lim_i};

  logic signed [63:0] accr, tqr;
  logic signed [25:0] tlim;
  assign accr = acc_q + 64'sd4194304;
  assign tqr  = accr >>> 23;
  assign tlim = {2'b0, tq_lim_i};

  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    raddr = j_q;
    wd    = rd;
    case (state_q)
      StInit: begin
        we = 1'b1;
        wd = '{pos: '0, vel: '0, integ: '0, tgt: mjpid_pkg::home_target(j_q)};
      end
      StIdle: raddr = joint_i[JIdxW-1:0];
      StUpd: begin
        we = 1'b1;
        if (act_q == mjpid_pkg::ActMeas) begin
          wd.pos = ang_q;
          if (vv_q) wd.vel = vel_q;
        end else begin
          wd.tgt = ang_q;
        end
      end
      // new integral is registered by now
      StMul: begin
        we = 1'b1;
        wd.integ = integ_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      j_q     <= '0;
      seen_q  <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      act_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StInit: begin
          if (j_q == JIdxW'(mjpid_pkg::NumJoints - 1)) begin
            j_q     <= '0;
            state_q <= StIdle;
          end else j_q <= j_q + 1'b1;
        end
        StIdle: if (start_i) begin
          act_q <= action_i;
          ang_q <= angle_i;
          vel_q <= velocity_i;
          vv_q  <= velocity_valid_i;
          if ((action_i == mjpid_pkg::ActMeas || action_i == mjpid_pkg::ActTarget)
              && in_range) begin
            j_q     <= joint_i[JIdxW-1:0];
            state_q <= StRead;
            if (action_i == mjpid_pkg::ActMeas) seen_q[joint_i[JIdxW-1:0]] <= 1'b1;
          end else if (action_i == mjpid_pkg::ActTick && &seen_q) begin
            j_q     <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= (act_q == mjpid_pkg::ActTick) ? StErr : StUpd;
        StUpd:  state_q <= StIdle;
        StErr: begin
          err_q   <= e2;
          state_q <= StDt;
        end
        StDt: begin
          dt_q    <= err_q * $signed({1'b0, mjpid_pkg::DtQ32});
          state_q <= StInt;
        end
        StInt: begin
          if (isum > ilim) integ_q <= AW'(ilim);
          else if (isum < -ilim) integ_q <= AW'(-ilim);
          else integ_q <= AW'(isum);
          state_q <= StMul;
        end
        StMul: begin
          p_q     <= 54'(kp * err_q);
          i_q     <= 54'(ki * integ_q);
          d_q     <= 54'(kd * rd.vel);
          state_q <= StSum;
        end
        StSum: begin
          acc_q   <= 64'(p_q) + 64'(i_q) - (64'(d_q) <<< 7);
          state_q <= StOut;
        end
        StOut: begin
          if (tqr > 64'(tlim)) tq_q <= 25'(tlim);
          else if (tqr < -64'(tlim)) tq_q <= 25'(-tlim);
          else tq_q <= 25'(tqr);
          jout_q  <= mjpid_pkg::JointW'(j_q);
          valid_q <= 1'b1;
          last_q  <= j_q == JIdxW'(mjpid_pkg::NumJoints - 1);
          if (j_q == JIdxW'(mjpid_pkg::NumJoints - 1)) begin
            state_q <= StIdle;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= StRead;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = state_q != StIdle;
  assign valid_o     = valid_q;
  assign joint_out_o = jout_q;
  assign torque_o    = tq_q;
  assign last_o      = last_q;

endmodule

[tb/multi_joint_pid_torque_chk.sv]
// ----------------------------------------------------------------------------
// multi_joint_pid_torque_chk
// Watches the command, config and result ports, keeps its own model of the
// joint state and gains, and compares every torque transfer in order.
// ----------------------------------------------------------------------------
module multi_joint_pid_torque_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           action_i,
  input  logic [mjpid_pkg::JointW-1:0]         joint_i,
  input  logic signed [mjpid_pkg::AngleW-1:0]  angle_i,
  input  logic signed [mjpid_pkg::VelW-1:0]    velocity_i,
  input  logic                                 velocity_valid_i,
  input  logic                                 cfg_we_i,
  input  logic [mjpid_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mjpid_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                 valid_o,
  input  logic [mjpid_pkg::JointW-1:0]         joint_out_o,
  input  logic signed [mjpid_pkg::TorqueW-1:0] torque_o,
  input  logic                                 last_o,
  output int                                   err_cnt_o,
  output int                                   pending_o
);
  import mjpid_pkg::*;

  typedef struct packed {
    logic [JointW-1:0]         jnt;
    logic signed [TorqueW-1:0] tq;
    logic                      lst;
  } torque_cmd_t;

  torque_cmd_t  torque_q[$];
  logic [CfgDataW-1:0] gain_reg[GainRegs];
  longint       int_lim, tq_lim;
  longint       pos_m[NumJoints], vel_m[NumJoints], tgt_m[NumJoints], integ_m[NumJoints];
  bit           seen_m[NumJoints];

  assign pending_o = torque_q.size();

  // round to nearest, ties up
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic run_tick();
    longint err, kp, ki, kd, acc;
    torque_cmd_t c;
    for (int j = 0; j < NumJoints; j++) if (!seen_m[j]) return;
    for (int j = 0; j < NumJoints; j++) begin
      err = tgt_m[j] - pos_m[j];
      while (err > longint'(PiQ)) err -= longint'(TwoPiQ);
      while (err < -longint'(PiQ)) err += longint'(TwoPiQ);
      integ_m[j] = sat(integ_m[j] + round_shift(err * longint'(DtQ32), 32), int_lim);
      kp = longint'(gain_reg[j][59:40]);
      ki = longint'(gain_reg[j][39:20]);
      kd = longint'(gain_reg[j][19:0]);
      acc = kp * err + ki * integ_m[j] - kd * vel_m[j] * 128;
      c.jnt = j[JointW-1:0];
      c.tq  = TorqueW'(sat(round_shift(acc, 23), tq_lim));
      c.lst = (j == NumJoints - 1);
      torque_q.push_back(c);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    torque_cmd_t want;
    if (!rst_ni) begin
      for (int j = 0; j < GainRegs; j++) gain_reg[j] = GainsReset[j];
      int_lim = 671088640;
      tq_lim  = 5242880;
      for (int j = 0; j < NumJoints; j++) begin
        pos_m[j] = 0; vel_m[j] = 0; integ_m[j] = 0; seen_m[j] = 0;
        case (j)
          1, 4:    tgt_m[j] = -longint'(HalfPiQ);
          2:       tgt_m[j] = longint'(HalfPiQ);
          3:       tgt_m[j] = -longint'(PiQ);
          default: tgt_m[j] = 0;
        endcase
      end
      torque_q.delete();
      err_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegIntLim) int_lim = longint'(cfg_data_i[29:0]);
        else if (cfg_idx_i == RegTqLim) tq_lim = longint'(cfg_data_i[23:0]);
        else gain_reg[cfg_idx_i] = cfg_data_i;
      end
      if (valid_o) begin
        if (torque_q.size() == 0) begin
          $display("%0t: unexpected torque transfer joint %0d torque %0d last %0b",
                   $time, joint_out_o, torque_o, last_o);
          err_cnt_o++;
        end else begin
          want = torque_q.pop_front();
          if (want.jnt !== joint_out_o || want.tq !== torque_o || want.lst !== last_o) begin
            $display("%0t: mismatch exp joint %0d torque %0d last %0b, got %0d %0d %0b",
                     $time, want.jnt, want.tq, want.lst, joint_out_o, torque_o, last_o);
            err_cnt_o++;
          end
        end
      end
      if (start && !busy) begin
        if (action_i == ActMeas && joint_i < NumJoints) begin
          pos_m[joint_i] = longint'(angle_i);
          if (velocity_valid_i) vel_m[joint_i] = longint'(velocity_i);
          seen_m[joint_i] = 1;
        end else if (action_i == ActTarget && joint_i < NumJoints) begin
          tgt_m[joint_i] = longint'(angle_i);
        end else if (action_i == ActTick) begin
          run_tick();
        end
      end
    end
  end

endmodule

[tb/multi_joint_pid_torque_tb.sv]
// ----------------------------------------------------------------------------
// multi_joint_pid_torque_tb
// Drives commands in random bursts through several gain and limit settings;
// a checker beside the block predicts and compares every torque transfer.
// ----------------------------------------------------------------------------
module multi_joint_pid_torque_tb;
  import mjpid_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int Drain      = 80;
  localparam logic [1:0] ActNone = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic [JointW-1:0] joint_i = '0;
  logic signed [AngleW-1:0] angle_i = '0;
  logic signed [VelW-1:0] velocity_i = '0;
  logic velocity_valid_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic valid_o, last_o;
  logic [JointW-1:0] joint_out_o;
  logic signed [TorqueW-1:0] torque_o;
  int err_cnt, pending, cycles = 0;
  int burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("multi_joint_pid_torque_tb: done, errors");
      $finish;
    end
  end

  multi_joint_pid_torque i_dut (.*);

  multi_joint_pid_torque_chk i_chk (
    .*, .err_cnt_o(err_cnt), .pending_o(pending)
  );

  task automatic send_cmd(logic [1:0] act, logic [JointW-1:0] jnt, logic [AngleW-1:0] ang,
                          logic [VelW-1:0] vel, logic vv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    action_i = act; joint_i = jnt; angle_i = ang; velocity_i = vel; velocity_valid_i = vv;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // mode 0 random, 1 all ones, 2 zero limits with random gains
  task automatic load_settings(int mode);
    for (int r = 0; r < GainRegs; r++)
      write_reg(CfgIdxW'(r), mode == 1 ? {CfgDataW{1'b1}}
                                       : CfgDataW'({$urandom, $urandom}));
    write_reg(RegIntLim, mode == 1 ? 60'h3FFF_FFFF : mode == 2 ? 60'd0
                                   : 60'($urandom_range(0, 32'h3FFF_FFFF)));
    write_reg(RegTqLim, mode == 1 ? 60'hFF_FFFF : mode == 2 ? 60'd0
                                  : 60'($urandom_range(0, 24'hFF_FFFF)));
  endtask

  task automatic random_items(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      send_cmd(pick < 40 ? ActMeas : pick < 65 ? ActTarget : pick < 95 ? ActTick : ActNone,
               JointW'(pick % 9 == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5)),
               AngleW'($urandom), VelW'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // tick before every joint is seen: no output
    send_cmd(ActTick, '0, '0, '0, 1'b0);
    send_cmd(ActNone, 3'd2, 31'h7FFF_FFFF, '1, 1'b1);
    send_cmd(ActMeas, 3'd0, 31'h4000_0000, 28'h800_0000, 1'b1);
    send_cmd(ActMeas, 3'd1, 31'h3FFF_FFFF, 28'h7FF_FFFF, 1'b1);
    send_cmd(ActMeas, 3'd2, '0, '0, 1'b1);
    send_cmd(ActMeas, 3'd3, '1, '1, 1'b0);
    send_cmd(ActMeas, 3'd4, 31'h1234_5678, 28'h0AB_CDEF, 1'b1);
    send_cmd(ActMeas, 3'd6, 31'h2000_0000, 28'h123_4567, 1'b1);
    send_cmd(ActTick, '0, '0, '0, 1'b0);
    send_cmd(ActMeas, 3'd5, 31'h7FFF_FFFF, 28'h555_5555, 1'b1);
    send_cmd(ActTick, '0, '0, '0, 1'b0);
    send_cmd(ActTarget, 3'd0, 31'h3FFF_FFFF, '0, 1'b0);
    send_cmd(ActTarget, 3'd1, 31'h4000_0000, '0, 1'b0);
    send_cmd(ActTarget, 3'd7, 31'h1111_1111, '0, 1'b0);
    send_cmd(ActMeas, 3'd3, 31'h0, 28'h7FF_FFFF, 1'b0);
    send_cmd(ActTick, '0, '0, '0, 1'b0);
    send_cmd(ActTick, '0, '0, '0, 1'b0);
    go_idle();

    load_settings(1);
    random_items(45);
    go_idle();
    load_settings(2);
    random_items(30);
    go_idle();
    load_settings(0);
    random_items(50);
    go_idle();
    load_settings(0);
    random_items(45);
    go_idle();

    if (err_cnt == 0) begin
      $display("multi_joint_pid_torque_tb: done, clean");
    end else begin
      $display("multi_joint_pid_torque_tb: done, errors");
    end
    $finish;
  end

endmodule
